// ===== rtl/marker_tracking_velocity_law_top_defines.svh =====
// ----------------------------------------------------------------------------
// Marker tracking velocity law assertion macros
// Shared concurrent assertion forms for the checker of the velocity law block.
// ----------------------------------------------------------------------------
`ifndef MARKER_TRACKING_VELOCITY_LAW_TOP_DEFINES_SVH
`define MARKER_TRACKING_VELOCITY_LAW_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define MTVL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtvl assertion failed");

// Next-cycle implication, checked at every rising clock edge.
`define MTVL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtvl assertion failed");

`endif

// ===== rtl/mtvl_pkg.sv =====
// ----------------------------------------------------------------------------
// Marker tracking velocity law package
// Widths, register indexes, thresholds and helper functions of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtvl_pkg;

   localparam int VAL_W = 16;
   localparam int ERR_W = VAL_W + 1;
   localparam int CMD_W = VAL_W + 2;
   localparam int HISTORY_DEPTH_DEF = 4;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TARGET_R = 2'd2;

   localparam logic signed [VAL_W-1:0] TARGET_X_RST = 16'sd4096;
   localparam logic signed [VAL_W-1:0] TARGET_Y_RST = -16'sd2458;
   localparam logic signed [VAL_W-1:0] TARGET_R_RST = 16'sd0;

   localparam logic signed [ERR_W-1:0] DZ_XY = 17'sd410;
   localparam logic signed [ERR_W-1:0] NEG_DZ_XY = -17'sd410;
   localparam logic signed [ERR_W-1:0] DZ_R = 17'sd820;
   localparam logic signed [ERR_W-1:0] NEG_DZ_R = -17'sd820;
   localparam logic signed [ERR_W-1:0] CAP_X = 17'sd2048;
   localparam logic signed [VAL_W-1:0] STILL = 16'sd41;
   localparam logic signed [VAL_W-1:0] NEG_STILL = -16'sd41;
   localparam logic signed [VAL_W-1:0] FAST = 16'sd1228;
   localparam logic signed [VAL_W-1:0] NEG_FAST = -16'sd1228;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sd32767;
   localparam logic signed [VAL_W-1:0] VAL_MIN = -16'sd32768;
   localparam logic signed [CMD_W-1:0] CMD_MAX = 18'sd32767;
   localparam logic signed [CMD_W-1:0] CMD_MIN = -18'sd32768;

   function automatic logic signed [VAL_W-1:0] sat16(input logic signed [CMD_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > CMD_MAX) begin
         r = VAL_MAX;
      end else if (v < CMD_MIN) begin
         r = VAL_MIN;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [CMD_W-1:0] reverse_boost(
      input logic signed [VAL_W-1:0] prev,
      input logic signed [CMD_W-1:0] v
   );
      logic signed [CMD_W-1:0] r;
      if ((prev < 16'sd0 && v > 18'sd0) || (prev > 16'sd0 && v < 18'sd0)) begin
         r = v <<< 1;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [ERR_W-1:0] abs17(input logic signed [VAL_W-1:0] v);
      logic signed [ERR_W-1:0] e;
      e = ERR_W'(v);
      return (e < 17'sd0) ? ERR_W'(-e) : ERR_W'(e);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mtvl_req_if.sv =====
// ----------------------------------------------------------------------------
// Marker pose channel
// Valid/ready channel that carries one measured marker pose per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtvl_req_if;
   logic valid;
   logic ready;
   logic signed [mtvl_pkg::VAL_W-1:0] pos_x;
   logic signed [mtvl_pkg::VAL_W-1:0] pos_y;
   logic signed [mtvl_pkg::VAL_W-1:0] pos_r;

   modport source (output valid, output pos_x, output pos_y, output pos_r, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_r, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtvl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Velocity command channel
// Valid/ready channel that carries one velocity command set per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mtvl_rsp_if;
   logic valid;
   logic ready;
   logic signed [mtvl_pkg::VAL_W-1:0] vel_x;
   logic signed [mtvl_pkg::VAL_W-1:0] vel_y;
   logic signed [mtvl_pkg::VAL_W-1:0] vel_r;

   modport source (output valid, output vel_x, output vel_y, output vel_r, input ready);
   modport sink (input valid, input vel_x, input vel_y, input vel_r, output ready);
endinterface

`default_nettype wire

// ===== rtl/marker_tracking_velocity_law_top.sv =====
// A pose goes to the input register, then its command to the result register;
// each holds one item. Throughput: one pose per cycle unless the output stalls.
// The per-axis previous commands and the direction histories close a registered loop.
// Reset (synchronous, active high) empties both registers, clears the histories
// and previous commands, sets the direction latch positive and restores the targets.
// ----------------------------------------------------------------------------
// Marker tracking velocity law
// Turns a measured marker pose into saturated x, y and rotation velocity
// commands with dead zones, reversal boost and a rotation direction latch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module marker_tracking_velocity_law_top #(
   parameter int HISTORY_DEPTH = mtvl_pkg::HISTORY_DEPTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mtvl_req_if.sink                                req_if,
   mtvl_rsp_if.source                              rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [mtvl_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [mtvl_pkg::VAL_W-1:0]         csr_wdata
);
   import mtvl_pkg::*;

   logic                      s1_valid_ff;
   logic signed [VAL_W-1:0]   pos_x_ff, pos_y_ff, pos_r_ff;
   logic                      rsp_valid_ff;
   logic signed [VAL_W-1:0]   vel_x_ff, vel_y_ff, vel_r_ff;
   logic signed [VAL_W-1:0]   target_x_ff, target_y_ff, target_r_ff;
   logic signed [VAL_W-1:0]   prev_x_ff, prev_y_ff, prev_r_ff;
   logic signed [VAL_W-1:0]   rot_hist_ff [HISTORY_DEPTH];
   logic signed [VAL_W-1:0]   ang_hist_ff [HISTORY_DEPTH];
   logic                      turn_ff;
   logic                      turn_in;

   logic                      advance;
   logic signed [ERR_W-1:0]   ex, ey, er, ex_dz, ey_dz, er_dz;
   logic signed [CMD_W-1:0]   vx_raw, vy_raw, vr_raw;
   logic signed [VAL_W-1:0]   vx_sat, vy_sat, vr_sat, vr_mag, vr_in;
   logic                      moving, flip, fast;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.vel_x = vel_x_ff;
   assign rsp_if.vel_y = vel_y_ff;
   assign rsp_if.vel_r = vel_r_ff;

   always_comb begin
      ex = ERR_W'(pos_x_ff) - ERR_W'(target_x_ff);
      ey = ERR_W'(target_y_ff) - ERR_W'(pos_y_ff);
      er = ERR_W'(pos_r_ff) - ERR_W'(target_r_ff);

      ex_dz = (ex > NEG_DZ_XY && ex < DZ_XY) ? '0 : ex;
      ey_dz = (ey > NEG_DZ_XY && ey < DZ_XY) ? '0 : ey;
      er_dz = (er > NEG_DZ_R && er < DZ_R) ? '0 : er;

      vx_raw = CMD_W'((ex_dz > CAP_X) ? CAP_X : ex_dz);
      vr_raw = CMD_W'(er_dz >>> 1);
      // The halved rotation error is either zero or well outside the still band.
      vy_raw = (vr_raw == '0) ? CMD_W'(ey_dz >>> 2) : '0;

      vx_sat = sat16(reverse_boost(prev_x_ff, vx_raw));
      vy_sat = sat16(reverse_boost(prev_y_ff, vy_raw));
      vr_sat = sat16(reverse_boost(prev_r_ff, vr_raw));

      moving = 1'b1;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (rot_hist_ff[i] > NEG_STILL && rot_hist_ff[i] < STILL) begin
            moving = 1'b0;
         end
      end
      flip = moving && (abs17(ang_hist_ff[0]) < abs17(pos_r_ff));
      turn_in = turn_ff ^ flip;

      fast = (vr_sat > FAST) || (vr_sat < NEG_FAST);
      if (vr_sat < 16'sd0) begin
         vr_mag = (vr_sat == VAL_MIN) ? VAL_MAX : -vr_sat;
      end else begin
         vr_mag = vr_sat;
      end

      if (fast) begin
         vr_in = turn_in ? vr_mag : -vr_mag;
      end else if ((turn_in && vr_sat < 16'sd0) || (!turn_in && vr_sat > 16'sd0)) begin
         vr_in = '0;
      end else begin
         vr_in = vr_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= TARGET_X_RST;
         target_y_ff <= TARGET_Y_RST;
         target_r_ff <= TARGET_R_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TARGET_X: target_x_ff <= csr_wdata;
            CSR_TARGET_Y: target_y_ff <= csr_wdata;
            CSR_TARGET_R: target_r_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         pos_x_ff <= req_if.pos_x;
         pos_y_ff <= req_if.pos_y;
         pos_r_ff <= req_if.pos_r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vel_x_ff <= vx_sat;
         vel_y_ff <= vy_sat;
         vel_r_ff <= vr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         prev_r_ff <= '0;
         turn_ff <= 1'b1;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            rot_hist_ff[i] <= '0;
            ang_hist_ff[i] <= '0;
         end
      end else if (advance) begin
         prev_x_ff <= vx_sat;
         prev_y_ff <= vy_sat;
         prev_r_ff <= vr_sat;
         turn_ff <= turn_in;
         for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
            ang_hist_ff[i] <= ang_hist_ff[i + 1];
            rot_hist_ff[i] <= flip ? '0 : rot_hist_ff[i + 1];
         end
         ang_hist_ff[HISTORY_DEPTH - 1] <= pos_r_ff;
         rot_hist_ff[HISTORY_DEPTH - 1] <= vr_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mtvl_checker.sv =====
// ----------------------------------------------------------------------------
// Marker tracking velocity law checker
// Port-level assertions on the pose and command channels, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "marker_tracking_velocity_law_top_defines.svh"

module mtvl_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [mtvl_pkg::VAL_W-1:0]      vel_x,
   input wire logic [mtvl_pkg::VAL_W-1:0]      vel_y,
   input wire logic [mtvl_pkg::VAL_W-1:0]      vel_r
);
   import mtvl_pkg::*;

   `MTVL_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   `MTVL_ASSERT_NOW(a_ready_when_drained, clock, reset, !rsp_valid || rsp_ready, req_ready)
   `MTVL_ASSERT_NEXT(a_two_cycle_latency, clock, reset, (req_valid && req_ready) ##1 !reset, rsp_valid)
   `MTVL_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(vel_x) && $stable(vel_y) && $stable(vel_r))
   `MTVL_ASSERT_NOW(a_rot_not_min, clock, reset, rsp_valid, vel_r != VAL_MIN)

endmodule

bind marker_tracking_velocity_law_top mtvl_checker u_mtvl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .vel_x     (rsp_if.vel_x),
   .vel_y     (rsp_if.vel_y),
   .vel_r     (rsp_if.vel_r)
);

`default_nettype wire
